// File: hw/rtl/polynomial_add_sub_mul_unit_assert.svh
// assertion helpers for the polynomial unit
`ifndef POLYNOMIAL_ADD_SUB_MUL_UNIT_ASSERT_SVH
`define POLYNOMIAL_ADD_SUB_MUL_UNIT_ASSERT_SVH

// same-cycle implication
`define PSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/psm_pkg.sv
package psm_pkg;

	localparam int ExpW  = 5;
	localparam int CoefW = 16;
	localparam int OExpW = 6;
	localparam int AccW  = 40;
	localparam int ProdW = 32;

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_SUB  = 2'd1;
	localparam logic [1:0] OP_MUL  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [OExpW-1:0] MaxResults = 6'd63;

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	typedef struct packed {
		logic [ExpW-1:0]         exponent;
		logic signed [CoefW-1:0] coefficient;
	} term_t;

endpackage

// File: hw/rtl/polynomial_add_sub_mul_unit.sv
// sparse polynomial add / subtract / multiply unit
//
// input channel (in_valid / in_ready): load items append a term to store A or
// B (taken one per cycle while the unit is idle); a run item starts add,
// subtract or multiply (OP_NONE only empties the stores), and in_ready stays
// low until the whole result run has been handed to the output register.
// output channel (out_valid / out_ready): one item per result term, last_term
// on the final one; an empty result gives a single item with term_valid low.
// steps: add/subtract read both term stores, then compare and produce one
// merged term, and end once both stores are seen used up; multiply clears
// all 2*MAX_DEGREE+1 entries of the accumulator memory, then per term pair
// reads the terms, multiplies, and does an accumulator read-modify-write
// (one access at a time so no forwarding is needed), then scans the
// accumulator entries for nonzero sums, and closes the run.
// one result is held back so last_term can be set; a stalled receiver stalls
// the sequencer once both the output register and the held result are full.
// reset clears counts, sequencer and output valid; the term stores and the
// accumulator memory hold no reset value.
`include "polynomial_add_sub_mul_unit_assert.svh"

module polynomial_add_sub_mul_unit #(
	parameter int MAX_TERMS  = 32,
	parameter int MAX_DEGREE = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [psm_pkg::ExpW-1:0]            term_exponent,
	input  logic signed [psm_pkg::CoefW-1:0]    term_coefficient,
	input  logic [1:0]                          operation,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [psm_pkg::OExpW-1:0]           out_exponent,
	output logic signed [psm_pkg::AccW-1:0]     out_coefficient,
	output logic                                term_valid,
	output logic                                last_term
);
	import psm_pkg::*;

	localparam int TAW = $clog2(MAX_TERMS);
	localparam int CW  = $clog2(MAX_TERMS + 1);
	localparam int ACC_DEPTH = 2 * MAX_DEGREE + 1;
	localparam int AAW = $clog2(ACC_DEPTH);

	// sequencer states
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_M_RD  = 10'b00_0000_0010,  // merge: read both stores
		ST_M_CMP = 10'b00_0000_0100,  // merge: compare and produce
		ST_C_CLR = 10'b00_0000_1000,  // clear accumulators
		ST_X_RD  = 10'b00_0001_0000,  // multiply: read term pair
		ST_X_MUL = 10'b00_0010_0000,  // multiply, read accumulator
		ST_X_ACC = 10'b00_0100_0000,  // accumulate and write back
		ST_S_RD  = 10'b00_1000_0000,  // scan: read accumulator
		ST_S_CHK = 10'b01_0000_0000,  // scan: produce nonzero
		ST_FLUSH = 10'b10_0000_0000   // close the run
	} state_t;

	state_t state_q, state_nxt;

	logic [CW-1:0]   count_a_q, count_b_q, i_q, j_q;
	logic [AAW-1:0]  addr_q;
	logic [OExpW-1:0] k_q;
	logic            sub_q;

	logic                   pend_v_q;
	logic [OExpW-1:0]       pend_exp_q;
	logic signed [AccW-1:0] pend_coef_q;

	logic                   out_valid_q, out_tv_q, out_last_q;
	logic [OExpW-1:0]       out_exp_q;
	logic signed [AccW-1:0] out_coef_q;

	logic signed [ProdW-1:0] prod_s1;
	logic [OExpW-1:0]        idx_s1;
	logic                    idx_ok_s1;

	// handshakes
	logic in_fire;
	logic slot_free;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// term stores
	term_t a_rd, b_rd, a_wr, b_wr;
	logic  we_a, we_b;

	assign we_a = in_fire && (req_type == REQ_LOAD_A) && (count_a_q < CW'(MAX_TERMS))
		&& (term_exponent <= ExpW'(MAX_DEGREE));
	assign we_b = in_fire && (req_type == REQ_LOAD_B) && (count_b_q < CW'(MAX_TERMS))
		&& (term_exponent <= ExpW'(MAX_DEGREE));
	assign a_wr = '{exponent: term_exponent, coefficient: term_coefficient};
	assign b_wr = a_wr;

	psm_ram #(.WIDTH($bits(term_t)), .DEPTH(MAX_TERMS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (count_a_q[TAW-1:0]),
		.wdata (a_wr),
		.raddr (i_q[TAW-1:0]),
		.rdata (a_rd)
	);

	psm_ram #(.WIDTH($bits(term_t)), .DEPTH(MAX_TERMS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (count_b_q[TAW-1:0]),
		.wdata (b_wr),
		.raddr (j_q[TAW-1:0]),
		.rdata (b_rd)
	);

	// accumulator memory
	logic [OExpW-1:0]        idx_calc;
	logic signed [AccW-1:0]  acc_rd, acc_wdata, acc_sat;
	logic signed [AccW:0]    acc_sum;
	logic                    acc_we;
	logic [AAW-1:0]          acc_waddr, acc_raddr;

	assign idx_calc  = OExpW'(a_rd.exponent) + OExpW'(b_rd.exponent);
	assign acc_raddr = (state_q == ST_X_MUL) ? idx_calc[AAW-1:0] : addr_q;
	assign acc_sum   = $signed({acc_rd[AccW-1], acc_rd}) + (AccW+1)'(prod_s1);
	assign acc_sat   = (acc_sum[AccW] != acc_sum[AccW-1])
		? (acc_sum[AccW] ? AccMin : AccMax) : acc_sum[AccW-1:0];
	assign acc_we    = (state_q == ST_C_CLR) || ((state_q == ST_X_ACC) && idx_ok_s1);
	assign acc_waddr = (state_q == ST_C_CLR) ? addr_q : idx_s1[AAW-1:0];
	assign acc_wdata = (state_q == ST_C_CLR) ? '0 : acc_sat;

	psm_ram #(.WIDTH(AccW), .DEPTH(ACC_DEPTH)) u_ram_acc (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rd)
	);

	// merge compare
	logic                  a_live, b_live;
	logic signed [CoefW:0] a_ext, b_neg;
	logic signed [CoefW+1:0] ab_sum;
	assign a_live = i_q < count_a_q;
	assign b_live = j_q < count_b_q;
	assign a_ext  = (CoefW+1)'(a_rd.coefficient);
	assign b_neg  = sub_q ? -(CoefW+1)'(b_rd.coefficient) : (CoefW+1)'(b_rd.coefficient);
	assign ab_sum = (CoefW+2)'(a_ext) + (CoefW+2)'(b_neg);

	// result produced this cycle, before the held-back register
	logic                   res_v, adv_i, adv_j, merge_done;
	logic [OExpW-1:0]       res_exp;
	logic signed [AccW-1:0] res_coef;

	always_comb begin
		res_v      = 1'b0;
		res_exp    = '0;
		res_coef   = '0;
		adv_i      = 1'b0;
		adv_j      = 1'b0;
		merge_done = 1'b0;
		if (state_q == ST_M_CMP) begin
			res_v = 1'b1;
			priority if (a_live && b_live && (a_rd.exponent > b_rd.exponent)) begin
				res_exp  = OExpW'(a_rd.exponent);
				res_coef = AccW'(a_ext);
				adv_i    = 1'b1;
			end else if (a_live && b_live && (a_rd.exponent < b_rd.exponent)) begin
				res_exp  = OExpW'(b_rd.exponent);
				res_coef = AccW'(b_neg);
				adv_j    = 1'b1;
			end else if (a_live && b_live) begin
				res_exp  = OExpW'(a_rd.exponent);
				res_coef = AccW'(ab_sum);
				adv_i    = 1'b1;
				adv_j    = 1'b1;
			end else if (a_live) begin
				res_exp  = OExpW'(a_rd.exponent);
				res_coef = AccW'(a_ext);
				adv_i    = 1'b1;
			end else if (b_live) begin
				res_exp  = OExpW'(b_rd.exponent);
				res_coef = AccW'(b_neg);
				adv_j    = 1'b1;
			end else begin
				res_v      = 1'b0;
				merge_done = 1'b1;
			end
		end else if (state_q == ST_S_CHK) begin
			res_v    = (acc_rd != '0);
			res_exp  = OExpW'(addr_q);
			res_coef = acc_rd;
		end
	end

	// results past the cap are dropped without stalling
	logic res_keep, stall, take, push_prod, flush_go, push, push_last;
	assign res_keep  = res_v && (k_q != MaxResults);
	assign stall     = res_keep && pend_v_q && !slot_free;
	assign take      = res_keep && !stall;
	assign push_prod = take && pend_v_q;
	assign flush_go  = (state_q == ST_FLUSH) && slot_free;
	assign push      = push_prod || flush_go;
	assign push_last = flush_go;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (req_type == REQ_RUN)) begin
					if ((operation == OP_ADD) || (operation == OP_SUB)) begin
						state_nxt = ST_M_RD;
					end else if (operation == OP_MUL) begin
						state_nxt = ST_C_CLR;
					end
				end
			end
			ST_M_RD:  state_nxt = ST_M_CMP;
			ST_M_CMP: begin
				if (merge_done) begin
					state_nxt = ST_FLUSH;
				end else if (!stall) begin
					state_nxt = ST_M_RD;
				end
			end
			ST_C_CLR: begin
				if (addr_q == AAW'(ACC_DEPTH - 1)) begin
					state_nxt = ((count_a_q == '0) || (count_b_q == '0)) ? ST_S_RD : ST_X_RD;
				end
			end
			ST_X_RD:  state_nxt = ST_X_MUL;
			ST_X_MUL: state_nxt = ST_X_ACC;
			ST_X_ACC: begin
				if ((j_q + 1'b1 == count_b_q) && (i_q + 1'b1 == count_a_q)) begin
					state_nxt = ST_S_RD;
				end else begin
					state_nxt = ST_X_RD;
				end
			end
			ST_S_RD:  state_nxt = ST_S_CHK;
			ST_S_CHK: begin
				if (!stall) begin
					state_nxt = (addr_q == '0) ? ST_FLUSH : ST_S_RD;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			i_q         <= '0;
			j_q         <= '0;
			addr_q      <= '0;
			k_q         <= '0;
			sub_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (we_a) begin
				count_a_q <= count_a_q + 1'b1;
			end
			if (we_b) begin
				count_b_q <= count_b_q + 1'b1;
			end
			if (in_fire && (req_type == REQ_RUN)) begin
				i_q    <= '0;
				j_q    <= '0;
				k_q    <= '0;
				addr_q <= '0;
				sub_q  <= (operation == OP_SUB);
				if (operation == OP_NONE) begin
					count_a_q <= '0;
					count_b_q <= '0;
				end
			end
			// merge indices
			if ((state_q == ST_M_CMP) && !stall) begin
				if (adv_i) begin
					i_q <= i_q + 1'b1;
				end
				if (adv_j) begin
					j_q <= j_q + 1'b1;
				end
			end
			// accumulator address sweep
			if (state_q == ST_C_CLR) begin
				if (addr_q == AAW'(ACC_DEPTH - 1)) begin
					if ((count_a_q == '0) || (count_b_q == '0)) begin
						addr_q <= AAW'(ACC_DEPTH - 1);
					end
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			// term pair loop
			if (state_q == ST_X_ACC) begin
				if (j_q + 1'b1 == count_b_q) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == count_a_q) begin
						addr_q <= AAW'(ACC_DEPTH - 1);
					end
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if ((state_q == ST_S_CHK) && !stall && (addr_q != '0)) begin
				addr_q <= addr_q - 1'b1;
			end
			// held-back result
			if (take) begin
				pend_v_q <= 1'b1;
				k_q      <= k_q + 1'b1;
			end
			if (flush_go) begin
				pend_v_q  <= 1'b0;
				count_a_q <= '0;
				count_b_q <= '0;
			end
			// output register
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			pend_exp_q  <= res_exp;
			pend_coef_q <= res_coef;
		end
		if (push) begin
			out_exp_q  <= pend_v_q ? pend_exp_q : '0;
			out_coef_q <= pend_v_q ? pend_coef_q : '0;
			out_tv_q   <= pend_v_q;
			out_last_q <= push_last;
		end
		if (state_q == ST_X_MUL) begin
			prod_s1   <= ProdW'(a_rd.coefficient) * ProdW'(b_rd.coefficient);
			idx_s1    <= idx_calc;
			idx_ok_s1 <= idx_calc < OExpW'(ACC_DEPTH);
		end
	end

	assign out_valid       = out_valid_q;
	assign out_exponent    = out_exp_q;
	assign out_coefficient = out_coef_q;
	assign term_valid      = out_tv_q;
	assign last_term       = out_last_q;

	// checks
	`PSM_ASSERT_NOW(a_idle_no_pending, in_ready, !pend_v_q, "held result left over while idle")
	`PSM_ASSERT_NEXT(a_flush_empties, flush_go,
		(state_q == ST_IDLE) && (count_a_q == '0) && (count_b_q == '0) && !pend_v_q,
		"run did not close cleanly")
	`PSM_ASSERT_NOW(a_cap, take, k_q != MaxResults, "result beyond the cap was kept")

endmodule

// File: hw/rtl/psm_ram.sv
module psm_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sim/polynomial_add_sub_mul_unit_test.sv
`timescale 1ns / 100ps

module polynomial_add_sub_mul_unit_test;
	import psm_pkg::*;

	localparam int TERM_CAP   = 32;
	localparam int DEGREE_CAP = 31;
	localparam int SUM_DEPTH  = 2 * DEGREE_CAP + 1;
	localparam int CYCLE_LIMIT = 600000;
	localparam longint SUM_MAX = 64'sd549755813887;
	localparam longint SUM_MIN = -64'sd549755813888;

	typedef struct {
		logic [OExpW-1:0]        exponent;
		logic signed [AccW-1:0]  coefficient;
		logic                    valid;
		logic                    last;
	} poly_term_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              req_type;
	logic [ExpW-1:0]         term_exponent;
	logic signed [CoefW-1:0] term_coefficient;
	logic [1:0]              operation;
	logic                    out_valid;
	logic                    out_ready;
	logic [OExpW-1:0]        out_exponent;
	logic signed [AccW-1:0]  out_coefficient;
	logic                    term_valid;
	logic                    last_term;

	// predictor copy of the operand stores
	term_t      store_a [TERM_CAP];
	term_t      store_b [TERM_CAP];
	int         fill_a;
	int         fill_b;
	poly_term_t expected_terms[$];

	int  errors;
	int  cycles;
	bit  calm;        // no idling on either side
	int  long_hold;   // receiver hold-off requested, in cycles
	int  stall_left;

	polynomial_add_sub_mul_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.term_exponent    (term_exponent),
		.term_coefficient (term_coefficient),
		.operation        (operation),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_exponent     (out_exponent),
		.out_coefficient  (out_coefficient),
		.term_valid       (term_valid),
		.last_term        (last_term)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	// push one result, honoring the 63-term cap of the output run
	function automatic void push_term(ref poly_term_t run[$], input longint e,
		input longint c);
		poly_term_t t;
		if (run.size() >= int'(MaxResults))
			return;
		t.exponent    = e[OExpW-1:0];
		t.coefficient = c[AccW-1:0];
		t.valid       = 1'b1;
		t.last        = 1'b0;
		run.push_back(t);
	endfunction

	// descending merge of the two stores, b negated for subtract
	function automatic void merge_poly(ref poly_term_t run[$], input bit negate_b);
		int     i;
		int     j;
		longint bc;
		i = 0;
		j = 0;
		while (i < fill_a && j < fill_b) begin
			bc = negate_b ? -longint'(store_b[j].coefficient)
				: longint'(store_b[j].coefficient);
			if (store_a[i].exponent > store_b[j].exponent) begin
				push_term(run, store_a[i].exponent, store_a[i].coefficient);
				i++;
			end else if (store_a[i].exponent < store_b[j].exponent) begin
				push_term(run, store_b[j].exponent, bc);
				j++;
			end else begin
				push_term(run, store_a[i].exponent, longint'(store_a[i].coefficient) + bc);
				i++;
				j++;
			end
		end
		for (; i < fill_a; i++)
			push_term(run, store_a[i].exponent, store_a[i].coefficient);
		for (; j < fill_b; j++) begin
			bc = negate_b ? -longint'(store_b[j].coefficient)
				: longint'(store_b[j].coefficient);
			push_term(run, store_b[j].exponent, bc);
		end
	endfunction

	// saturating per-exponent product sums, emitted nonzero from the top
	function automatic void multiply_poly(ref poly_term_t run[$]);
		longint sums [SUM_DEPTH];
		longint s;
		int     idx;
		foreach (sums[k])
			sums[k] = 0;
		for (int i = 0; i < fill_a; i++)
			for (int j = 0; j < fill_b; j++) begin
				idx = store_a[i].exponent + store_b[j].exponent;
				if (idx >= SUM_DEPTH)
					continue;
				s = sums[idx] + longint'(store_a[i].coefficient)
					* longint'(store_b[j].coefficient);
				if (s > SUM_MAX)
					s = SUM_MAX;
				if (s < SUM_MIN)
					s = SUM_MIN;
				sums[idx] = s;
			end
		for (int e = SUM_DEPTH - 1; e >= 0; e--)
			if (sums[e] != 0)
				push_term(run, e, sums[e]);
	endfunction

	// update the stores for one accepted item and queue its results
	function automatic void predict_poly_result(input logic [1:0] rq,
		input logic [ExpW-1:0] ex, input logic signed [CoefW-1:0] cf,
		input logic [1:0] op);
		poly_term_t run[$];
		poly_term_t blank;
		if (rq == REQ_LOAD_A || rq == REQ_LOAD_B) begin
			if (rq == REQ_LOAD_A && fill_a < TERM_CAP && ex <= DEGREE_CAP) begin
				store_a[fill_a] = '{exponent: ex, coefficient: cf};
				fill_a++;
			end
			if (rq == REQ_LOAD_B && fill_b < TERM_CAP && ex <= DEGREE_CAP) begin
				store_b[fill_b] = '{exponent: ex, coefficient: cf};
				fill_b++;
			end
			return;
		end
		if (rq != REQ_RUN)
			return;
		if (op == OP_MUL)
			multiply_poly(run);
		else if (op != OP_NONE)
			merge_poly(run, op == OP_SUB);
		if (op != OP_NONE) begin
			if (run.size() == 0) begin
				blank = '{exponent: '0, coefficient: '0, valid: 1'b0, last: 1'b0};
				run.push_back(blank);
			end
			run[run.size() - 1].last = 1'b1;
			foreach (run[k])
				expected_terms.push_back(run[k]);
		end
		fill_a = 0;
		fill_b = 0;
	endfunction

	// offer one item, hold it until accepted
	task automatic send_item(input logic [1:0] rq, input logic [ExpW-1:0] ex,
		input logic signed [CoefW-1:0] cf, input logic [1:0] op);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid         = 1'b1;
		req_type         = rq;
		term_exponent    = ex;
		term_coefficient = cf;
		operation        = op;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_poly_result(rq, ex, cf, op);
	endtask

	task automatic run_op(input logic [1:0] op);
		send_item(REQ_RUN, ExpW'($urandom), CoefW'($urandom), op);
	endtask

	// load up to n random terms with strictly descending exponents
	task automatic load_descending(input logic [1:0] rq, input int n);
		int e;
		e = DEGREE_CAP;
		for (int k = 0; k < n && e >= 0; k++) begin
			e = $urandom_range(e, (e > 8) ? e - 8 : 0);
			send_item(rq, ExpW'(e), CoefW'($urandom), OP_NONE);
			e--;
		end
	endtask

	task automatic wait_drained;
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_terms.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver: random short stalls plus requested long hold-offs
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				out_ready = 1'b0;
				long_hold--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready  = 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		poly_term_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_terms.size() == 0) begin
				flag_mismatch($sformatf("unexpected item exp %0d coef %0d",
					out_exponent, out_coefficient));
			end else begin
				want = expected_terms.pop_front();
				if (out_exponent !== want.exponent)
					flag_mismatch($sformatf("out_exponent %0d, want %0d",
						out_exponent, want.exponent));
				if (out_coefficient !== want.coefficient)
					flag_mismatch($sformatf("out_coefficient %0d, want %0d",
						out_coefficient, want.coefficient));
				if (term_valid !== want.valid)
					flag_mismatch($sformatf("term_valid %b, want %b",
						term_valid, want.valid));
				if (last_term !== want.last)
					flag_mismatch($sformatf("last_term %b, want %b",
						last_term, want.last));
			end
		end
	end

	// extremes of the fields, every operation, empty and odd requests
	task automatic test_edges;
		send_item(REQ_LOAD_A, 5'd31, 16'sh7fff, OP_NONE);
		send_item(REQ_LOAD_A, 5'd0, -16'sd32768, OP_NONE);
		send_item(REQ_LOAD_B, 5'd31, 16'sh7fff, OP_NONE);
		send_item(REQ_LOAD_B, 5'd3, -16'sd1, OP_NONE);
		run_op(OP_ADD);
		send_item(REQ_LOAD_A, 5'd4, 16'sd5, OP_NONE);
		send_item(REQ_LOAD_B, 5'd4, 16'sd5, OP_NONE);
		send_item(REQ_LOAD_B, 5'd0, -16'sd32768, OP_NONE);
		run_op(OP_SUB);   // zero difference is kept
		send_item(REQ_LOAD_A, 5'd31, -16'sd32768, OP_NONE);
		send_item(REQ_LOAD_A, 5'd0, 16'sd1, OP_NONE);
		send_item(REQ_LOAD_B, 5'd31, -16'sd32768, OP_NONE);
		send_item(REQ_LOAD_B, 5'd0, -16'sd1, OP_NONE);
		run_op(OP_MUL);
		run_op(OP_ADD);   // both stores empty
		send_item(REQ_LOAD_A, 5'd7, 16'sd9, OP_NONE);
		run_op(OP_MUL);   // empty product
		send_item(REQ_LOAD_A, 5'd1, 16'sd1, OP_NONE);
		send_item(REQ_LOAD_B, 5'd2, 16'sd2, OP_NONE);
		run_op(OP_NONE);  // unknown op only empties the stores
		send_item(REQ_NONE, 5'd31, -16'sd1, OP_NONE);   // ignored
		send_item(REQ_LOAD_A, 5'd2, 16'sd3, OP_NONE);
		run_op(OP_SUB);
		wait_drained();
	endtask

	// full store A drops extra loads, stores with repeated exponents exceed 63 results
	task automatic test_result_overflow;
		for (int k = 0; k < TERM_CAP + 3; k++)
			send_item(REQ_LOAD_A, 5'd9, CoefW'(k + 1), OP_NONE);
		for (int k = 0; k < TERM_CAP; k++)
			send_item(REQ_LOAD_B, 5'd8, CoefW'(-k - 1), OP_NONE);
		run_op(OP_SUB);
		wait_drained();
	endtask

	// 512 maximal products saturate one accumulator
	task automatic test_saturation;
		for (int k = 0; k < TERM_CAP; k++)
			send_item(REQ_LOAD_A, 5'd0, -16'sd32768, OP_NONE);
		for (int k = 0; k < TERM_CAP / 2; k++)
			send_item(REQ_LOAD_B, 5'd0, -16'sd32768, OP_NONE);
		run_op(OP_MUL);
		wait_drained();
	endtask

	// unordered terms through merge and multiply
	task automatic test_out_of_order;
		for (int n = 0; n < 2; n++) begin
			for (int k = 0; k < 3; k++) begin
				send_item(REQ_LOAD_A, ExpW'($urandom), CoefW'($urandom), OP_NONE);
				send_item(REQ_LOAD_B, ExpW'($urandom), CoefW'($urandom), OP_NONE);
			end
			run_op(n ? OP_MUL : OP_ADD);
		end
		wait_drained();
	endtask

	// receiver holds off while runs keep arriving, so the input stalls
	task automatic test_backpressure;
		long_hold = 400;
		for (int n = 0; n < 3; n++) begin
			load_descending(REQ_LOAD_A, 4);
			load_descending(REQ_LOAD_B, 4);
			run_op(n == 2 ? OP_MUL : OP_ADD);
		end
		wait_drained();
	endtask

	// random polynomials, mostly well formed, some noise
	task automatic test_random;
		int  sent;
		int  pick;
		logic [1:0] op;
		sent = 0;
		while (sent < 12) begin
			if (sent > 6)
				calm = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				for (int k = $urandom_range(1, 4); k > 0; k--) begin
					send_item(2'($urandom), ExpW'($urandom), CoefW'($urandom), 2'($urandom));
					sent++;
				end
			end else begin
				load_descending(REQ_LOAD_A, $urandom_range(0, 3));
				load_descending(REQ_LOAD_B, $urandom_range(0, 3));
				sent += fill_a + fill_b + 1;
				op = ($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
				run_op(op);
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		req_type         = REQ_LOAD_A;
		term_exponent    = '0;
		term_coefficient = '0;
		operation        = OP_ADD;
		errors           = 0;
		cycles           = 0;
		calm             = 1'b0;
		long_hold        = 0;
		fill_a           = 0;
		fill_b           = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_edges();
		test_result_overflow();
		test_saturation();
		test_out_of_order();
		test_backpressure();
		test_random();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
